// ===== src/aur_pkg.sv =====
`default_nettype none

package aur_pkg;

  localparam int MAX_FRAMES  = 20;
  localparam int IDX_W       = $clog2(MAX_FRAMES + 1);
  localparam int ADDR_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FRAME_BYTES = 7;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int PART_W      = (FRAME_BYTES - 1) * 8;
  localparam int FNUM_W      = 5;
  localparam int COUNT_W     = 8;
  localparam int TIMER_W     = 16;

  localparam logic [TIMER_W-1:0] ACK_TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]         ACK_CODE          = 8'hff;

  typedef enum logic [2:0] {
    KIND_ECHO_HEAD   = 3'd0,
    KIND_ECHO_FRAME  = 3'd1,
    KIND_STORE_FRAME = 3'd2,
    KIND_STORE_HEAD  = 3'd3,
    KIND_DONE        = 3'd4,
    KIND_NACK        = 3'd5,
    KIND_TIMEOUT     = 3'd6,
    KIND_OVERFLOW    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_ECHO   = 2'd1,
    MODE_COMMIT = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] ftime;
  } frame_t;

  typedef struct packed {
    logic  start;
    mode_t mode;
    kind_t kind;
  } emit_cmd_t;

endpackage

`default_nettype wire

// ===== src/aur_frame_ram.sv =====
`default_nettype none

module aur_frame_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [aur_pkg::ADDR_W-1:0] waddr,
  input  wire aur_pkg::frame_t           wdata,
  input  wire logic                      re,
  input  wire logic [aur_pkg::ADDR_W-1:0] raddr,
  output aur_pkg::frame_t                rdata
);

  aur_pkg::frame_t mem [aur_pkg::MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/aur_emit.sv =====
`default_nettype none

module aur_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire aur_pkg::emit_cmd_t          cmd,
  input  wire logic [7:0]                  slot_in,
  input  wire logic [aur_pkg::COUNT_W-1:0] count_in,
  output logic                             busy,
  output logic                             rd_en,
  output logic [aur_pkg::ADDR_W-1:0]       rd_addr,
  input  wire aur_pkg::frame_t             rd_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_kind,
  output logic [7:0]                       out_slot,
  output logic [aur_pkg::FNUM_W-1:0]       out_fnum,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic [31:0]                      out_time,
  output logic                             out_last
);

  localparam int IW = aur_pkg::IDX_W;
  localparam int FW = aur_pkg::FNUM_W;
  localparam int CW = aur_pkg::COUNT_W;

  typedef enum logic [5:0] {
    E_IDLE  = 6'b000001,
    E_HEAD  = 6'b000010,
    E_READ  = 6'b000100,
    E_FRAME = 6'b001000,
    E_TAIL  = 6'b010000,
    E_DONE  = 6'b100000
  } est_t;

  est_t                state, state_next;
  aur_pkg::mode_t      mode_reg;
  aur_pkg::kind_t      kind_reg;
  logic [IW-1:0]       idx, idx_next, idx_inc;
  logic [31:0]         total, total_next;
  logic                idx_end, count_zero, free;
  logic                load, ld_last;
  aur_pkg::kind_t      ld_kind;
  logic [FW-1:0]       ld_fnum;
  aur_pkg::frame_t     ld_frame;

  assign busy    = (state != E_IDLE);
  assign rd_addr = idx[aur_pkg::ADDR_W-1:0];

  always_comb begin
    state_next = state;
    idx_next   = idx;
    total_next = total;
    load       = 1'b0;
    rd_en      = 1'b0;
    ld_kind    = kind_reg;
    ld_fnum    = count_in[FW-1:0];
    ld_frame   = '0;
    ld_last    = 1'b0;
    idx_inc    = idx + 1'b1;
    idx_end    = (CW'(idx_inc) == count_in);
    count_zero = (count_in == '0);
    free       = !out_valid || out_ready;

    unique case (state)
      E_IDLE: begin
        if (cmd.start) begin
          idx_next   = '0;
          total_next = '0;
          unique case (cmd.mode)
            aur_pkg::MODE_COMMIT: state_next = count_zero ? E_TAIL : E_READ;
            default:              state_next = E_HEAD;
          endcase
        end
      end
      E_HEAD: begin
        if (free) begin
          load = 1'b1;
          if (mode_reg == aur_pkg::MODE_SINGLE) begin
            ld_kind    = kind_reg;
            ld_last    = 1'b1;
            state_next = E_IDLE;
          end else begin
            ld_kind    = aur_pkg::KIND_ECHO_HEAD;
            ld_last    = count_zero;
            state_next = count_zero ? E_IDLE : E_READ;
          end
        end
      end
      E_READ: begin
        rd_en      = 1'b1;
        state_next = E_FRAME;
      end
      E_FRAME: begin
        if (free) begin
          load       = 1'b1;
          ld_kind    = (mode_reg == aur_pkg::MODE_ECHO) ? aur_pkg::KIND_ECHO_FRAME
                                                        : aur_pkg::KIND_STORE_FRAME;
          ld_fnum    = FW'(idx);
          ld_frame   = rd_data;
          ld_last    = (mode_reg == aur_pkg::MODE_ECHO) && idx_end;
          total_next = rd_data.ftime;
          idx_next   = idx_inc;
          if (idx_end) begin
            state_next = (mode_reg == aur_pkg::MODE_ECHO) ? E_IDLE : E_TAIL;
          end else begin
            state_next = E_READ;
          end
        end
      end
      E_TAIL: begin
        if (free) begin
          load           = 1'b1;
          ld_kind        = aur_pkg::KIND_STORE_HEAD;
          ld_frame.ftime = total;
          state_next     = E_DONE;
        end
      end
      E_DONE: begin
        if (free) begin
          load       = 1'b1;
          ld_kind    = aur_pkg::KIND_DONE;
          ld_last    = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    total <= total_next;
    if (state == E_IDLE && cmd.start) begin
      mode_reg <= cmd.mode;
      kind_reg <= cmd.kind;
    end
    if (load) begin
      out_kind  <= ld_kind;
      out_slot  <= slot_in;
      out_fnum  <= ld_fnum;
      out_red   <= ld_frame.red;
      out_green <= ld_frame.green;
      out_blue  <= ld_frame.blue;
      out_time  <= ld_frame.ftime;
      out_last  <= ld_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/animation_upload_receiver_top.sv =====
// Animation upload receiver.
// Input channel (in_valid/in_ready, op, rx_byte): one serial byte (op 0) or one
// millisecond tick (op 1) per transaction. Output channel (out_valid/out_ready):
// one result per transaction; last marks the final result caused by an input.
// Config channel (cfg_valid/cfg_ready, ack_timeout_ms): always ready. It must be
// written only while the block is idle; the block itself does not enforce this.
// A byte or tick that produces no result leaves in_ready high, so the next
// transaction may follow in the next cycle. An input that produces results
// holds in_ready low while the result sequencer runs: it loads each header,
// done or error result directly and each frame result in two steps (frame
// memory read, then output load). The final result sits in the output register
// while the next input is accepted. The sequencer registers its state before
// it loads the first result into the output register, after a frame memory
// read when a commit opens with a frame. A stalled receiver (out_ready low)
// stops the sequencer at its next result. Reset returns the parser to waiting
// for the slot byte, empties the output register and sets the ack timeout limit
// to 1000; frame memory is not cleared.
`default_nettype none

module animation_upload_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       slot,
  output logic [4:0]       frame_number,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [31:0]      frame_time,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] ack_timeout_ms
);

  localparam int IW = aur_pkg::IDX_W;
  localparam int PW = aur_pkg::POS_W;
  localparam int CW = aur_pkg::COUNT_W;
  localparam logic [IW-1:0] IDX_FULL = IW'(aur_pkg::MAX_FRAMES);
  localparam logic [PW-1:0] POS_LAST = PW'(aur_pkg::FRAME_BYTES - 1);

  typedef enum logic [3:0] {
    PH_SLOT  = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_ACK   = 4'b1000
  } phase_t;

  phase_t                         phase, phase_next;
  logic [7:0]                     slot_reg, slot_reg_next;
  logic [CW-1:0]                  count_reg, count_reg_next;
  logic [IW-1:0]                  frame_idx, frame_idx_next, idx_inc;
  logic [PW-1:0]                  byte_pos, byte_pos_next;
  logic [aur_pkg::PART_W-1:0]     part_frame, part_frame_next;
  logic [aur_pkg::TIMER_W-1:0]    ack_timer, ack_timer_next;
  logic [aur_pkg::TIMER_W-1:0]    timeout_limit;
  logic                           accept, busy;
  aur_pkg::emit_cmd_t             cmd;
  logic                           mem_we;
  aur_pkg::frame_t                mem_wdata, rd_data;
  logic                           rd_en;
  logic [aur_pkg::ADDR_W-1:0]     rd_addr;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign mem_wdata = aur_pkg::frame_t'({part_frame, rx_byte});

  always_comb begin
    phase_next      = phase;
    slot_reg_next   = slot_reg;
    count_reg_next  = count_reg;
    frame_idx_next  = frame_idx;
    byte_pos_next   = byte_pos;
    part_frame_next = part_frame;
    ack_timer_next  = ack_timer;
    cmd.start       = 1'b0;
    cmd.mode        = aur_pkg::MODE_SINGLE;
    cmd.kind        = aur_pkg::KIND_NACK;
    mem_we          = 1'b0;
    idx_inc         = frame_idx + 1'b1;

    if (accept) begin
      if (op) begin
        if (phase == PH_ACK) begin
          if (ack_timer >= timeout_limit) begin
            cmd.start  = 1'b1;
            cmd.kind   = aur_pkg::KIND_TIMEOUT;
            phase_next = PH_SLOT;
          end else begin
            ack_timer_next = ack_timer + 1'b1;
          end
        end
      end else begin
        unique case (phase)
          PH_SLOT: begin
            slot_reg_next = rx_byte;
            phase_next    = PH_COUNT;
          end
          PH_COUNT: begin
            count_reg_next = rx_byte;
            frame_idx_next = '0;
            byte_pos_next  = '0;
            if (rx_byte == '0) begin
              cmd.start      = 1'b1;
              cmd.mode       = aur_pkg::MODE_ECHO;
              ack_timer_next = '0;
              phase_next     = PH_ACK;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (frame_idx == IDX_FULL) begin
              // buffer full: consume the byte and drop the packet
              cmd.start  = 1'b1;
              cmd.kind   = aur_pkg::KIND_OVERFLOW;
              phase_next = PH_SLOT;
            end else if (byte_pos == POS_LAST) begin
              mem_we         = 1'b1;
              frame_idx_next = idx_inc;
              byte_pos_next  = '0;
              if (CW'(idx_inc) == count_reg) begin
                cmd.start      = 1'b1;
                cmd.mode       = aur_pkg::MODE_ECHO;
                ack_timer_next = '0;
                phase_next     = PH_ACK;
              end
            end else begin
              part_frame_next = {part_frame[aur_pkg::PART_W-9:0], rx_byte};
              byte_pos_next   = byte_pos + 1'b1;
            end
          end
          PH_ACK: begin
            cmd.start  = 1'b1;
            cmd.mode   = (rx_byte == aur_pkg::ACK_CODE) ? aur_pkg::MODE_COMMIT
                                                        : aur_pkg::MODE_SINGLE;
            phase_next = PH_SLOT;
          end
          default: phase_next = PH_SLOT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SLOT;
      slot_reg      <= '0;
      count_reg     <= '0;
      frame_idx     <= '0;
      byte_pos      <= '0;
      ack_timer     <= '0;
      timeout_limit <= aur_pkg::ACK_TIMEOUT_RESET;
    end else begin
      phase     <= phase_next;
      slot_reg  <= slot_reg_next;
      count_reg <= count_reg_next;
      frame_idx <= frame_idx_next;
      byte_pos  <= byte_pos_next;
      ack_timer <= ack_timer_next;
      if (cfg_valid && cfg_ready) begin
        timeout_limit <= ack_timeout_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    part_frame <= part_frame_next;
  end

  aur_frame_ram u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (frame_idx[aur_pkg::ADDR_W-1:0]),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  aur_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .slot_in   (slot_reg),
    .count_in  (count_reg),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (kind),
    .out_slot  (slot),
    .out_fnum  (frame_number),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue),
    .out_time  (frame_time),
    .out_last  (last)
  );

  a_frame_idx_bound: assert property (@(posedge clk) disable iff (rst)
    frame_idx <= IDX_FULL)
    else $error("frame index beyond buffer");

  a_ack_byte_to_slot: assert property (@(posedge clk) disable iff (rst)
    accept && !op && phase == PH_ACK |=> phase == PH_SLOT && !in_ready)
    else $error("acknowledge byte did not end the packet");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy)
    else $error("result sequencer did not start");

  a_timer_bound: assert property (@(posedge clk) disable iff (rst)
    accept && op && phase == PH_ACK && ack_timer < timeout_limit |=> ack_timer != '0)
    else $error("ack timer wrapped");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int HEAD_BYTES = 2;
  localparam int BUF_BYTES  = aur_pkg::MAX_FRAMES * aur_pkg::FRAME_BYTES + HEAD_BYTES;

  typedef enum logic [1:0] {
    AWAIT_SLOT,
    AWAIT_COUNT,
    AWAIT_FRAMES,
    AWAIT_ACK
  } parse_phase_t;

  typedef struct packed {
    aur_pkg::kind_t kind;
    logic [7:0]     slot;
    logic [4:0]     frame_number;
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    logic [31:0]    frame_time;
    logic           last;
  } upload_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  slot;
  logic [4:0]  frame_number;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] frame_time;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] ack_timeout_ms = 16'd0;

  // shadow of the parser
  parse_phase_t phase_shadow   = AWAIT_SLOT;
  logic [7:0]   slot_shadow    = 8'd0;
  logic [7:0]   count_shadow   = 8'd0;
  int unsigned  bytes_shadow   = 0;
  logic [55:0]  frame_shadow [aur_pkg::MAX_FRAMES];
  logic [15:0]  timer_shadow   = 16'd0;
  logic [15:0]  timeout_shadow = aur_pkg::ACK_TIMEOUT_RESET;

  upload_result_t step_results[$];
  upload_result_t awaited_results[$];
  int bad_results = 0;
  int items_offered = 0;

  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_serial = 0;
  int hold_taken = 0;
  int hold_left = 0;

  animation_upload_receiver_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .slot          (slot),
    .frame_number  (frame_number),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .frame_time    (frame_time),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .ack_timeout_ms(ack_timeout_ms)
  );

  always #2 clk = ~clk;

  function automatic upload_result_t make_result(input aur_pkg::kind_t k,
                                                 input logic [4:0] fnum,
                                                 input logic [55:0] f, input bit with_frame,
                                                 input logic [31:0] t);
    upload_result_t r;
    r.kind         = k;
    r.slot         = slot_shadow;
    r.frame_number = fnum;
    r.red          = with_frame ? f[55:48] : 8'd0;
    r.green        = with_frame ? f[47:40] : 8'd0;
    r.blue         = with_frame ? f[39:32] : 8'd0;
    r.frame_time   = with_frame ? f[31:0] : t;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic void queue_echo();
    step_results.push_back(make_result(aur_pkg::KIND_ECHO_HEAD, count_shadow[4:0], '0,
                                       1'b0, '0));
    for (int i = 0; i < count_shadow && i < aur_pkg::MAX_FRAMES; i++)
      step_results.push_back(make_result(aur_pkg::KIND_ECHO_FRAME, 5'(i), frame_shadow[i],
                                         1'b1, '0));
    phase_shadow = AWAIT_ACK;
    timer_shadow = '0;
  endfunction

  function automatic void parse_upload_item(input logic op_i, input logic [7:0] b);
    int unsigned rel;
    logic [31:0] total;
    upload_result_t r;
    step_results.delete();
    if (op_i) begin
      // ticks matter only while the acknowledge is awaited
      if (phase_shadow == AWAIT_ACK) begin
        if (timer_shadow >= timeout_shadow) begin
          step_results.push_back(make_result(aur_pkg::KIND_TIMEOUT, count_shadow[4:0], '0,
                                             1'b0, '0));
          phase_shadow = AWAIT_SLOT;
        end else begin
          timer_shadow++;
        end
      end
    end else begin
      case (phase_shadow)
        AWAIT_SLOT: begin
          slot_shadow  = b;
          bytes_shadow = 1;
          phase_shadow = AWAIT_COUNT;
        end
        AWAIT_COUNT: begin
          count_shadow = b;
          bytes_shadow = HEAD_BYTES;
          if (b == 8'd0) queue_echo();
          else phase_shadow = AWAIT_FRAMES;
        end
        AWAIT_FRAMES: begin
          if (bytes_shadow >= BUF_BYTES) begin
            step_results.push_back(make_result(aur_pkg::KIND_OVERFLOW, count_shadow[4:0],
                                               '0, 1'b0, '0));
            phase_shadow = AWAIT_SLOT;
          end else begin
            rel = bytes_shadow - HEAD_BYTES;
            frame_shadow[rel / aur_pkg::FRAME_BYTES]
                        [(aur_pkg::FRAME_BYTES - 1 - rel % aur_pkg::FRAME_BYTES) * 8 +: 8] = b;
            bytes_shadow++;
            if (bytes_shadow == count_shadow * aur_pkg::FRAME_BYTES + HEAD_BYTES)
              queue_echo();
          end
        end
        default: begin
          if (b == aur_pkg::ACK_CODE) begin
            total = '0;
            for (int i = 0; i < count_shadow && i < aur_pkg::MAX_FRAMES; i++) begin
              step_results.push_back(make_result(aur_pkg::KIND_STORE_FRAME, 5'(i),
                                                 frame_shadow[i], 1'b1, '0));
              total = frame_shadow[i][31:0];
            end
            step_results.push_back(make_result(aur_pkg::KIND_STORE_HEAD, count_shadow[4:0],
                                               '0, 1'b0, total));
            step_results.push_back(make_result(aur_pkg::KIND_DONE, count_shadow[4:0], '0,
                                               1'b0, '0));
          end else begin
            step_results.push_back(make_result(aur_pkg::KIND_NACK, count_shadow[4:0], '0,
                                               1'b0, '0));
          end
          phase_shadow = AWAIT_SLOT;
        end
      endcase
    end
    foreach (step_results[i]) begin
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      awaited_results.push_back(r);
    end
  endfunction

  // receiver side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_serial != hold_taken) begin
      hold_taken = hold_serial;
      hold_left  = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    upload_result_t want;
    upload_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind         = aur_pkg::kind_t'(kind);
      got.slot         = slot;
      got.frame_number = frame_number;
      got.red          = red;
      got.green        = green;
      got.blue         = blue;
      got.frame_time   = frame_time;
      got.last         = last;
      if (awaited_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: kind=%0d slot=%h fnum=%0d rgb=%h/%h/%h time=%h last=%b",
                   got.kind, got.slot, got.frame_number, got.red, got.green, got.blue,
                   got.frame_time, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (want.kind !== got.kind || want.slot !== got.slot ||
            want.frame_number !== got.frame_number || want.red !== got.red ||
            want.green !== got.green || want.blue !== got.blue ||
            want.frame_time !== got.frame_time || want.last !== got.last) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch expected: kind=%0d slot=%h fnum=%0d rgb=%h/%h/%h time=%h last=%b",
                     want.kind, want.slot, want.frame_number, want.red, want.green, want.blue,
                     want.frame_time, want.last);
            $display("         actual:   kind=%0d slot=%h fnum=%0d rgb=%h/%h/%h time=%h last=%b",
                     got.kind, got.slot, got.frame_number, got.red, got.green, got.blue,
                     got.frame_time, got.last);
          end
        end
      end
    end
  end

  task automatic send_item(input logic op_i, input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= op_i;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_upload_item(op_i, b);
    items_offered++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_frames(input int n);
    repeat (n * aur_pkg::FRAME_BYTES) send_byte(8'($urandom));
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_ack_timeout(input logic [15:0] v);
    pause_until_drained();
    // let a transaction without results finish
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    ack_timeout_ms <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeout_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_idle_pct   = recv_pct;
  endtask

  // after reset a short run of ticks stays well inside the limit
  task automatic test_reset_timeout();
    send_byte(8'h3c);
    send_byte(8'h00);
    repeat (8) send_tick();
    send_byte(aur_pkg::ACK_CODE);
    pause_until_drained();
  endtask

  task automatic test_directed();
    write_ack_timeout(16'd2);
    send_tick();
    // empty packet, committed: total time is zero
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(aur_pkg::ACK_CODE);
    // one frame with every bit set
    send_byte(8'hff);
    send_byte(8'h01);
    repeat (aur_pkg::FRAME_BYTES) send_byte(8'hff);
    send_byte(aur_pkg::ACK_CODE);
    // empty packet, refused
    send_byte(8'h5a);
    send_byte(8'h00);
    send_byte(8'hfe);
    // acknowledge never comes
    send_byte(8'h81);
    send_byte(8'h00);
    repeat (3) send_tick();
    pause_until_drained();
  endtask

  task automatic test_timeout_register();
    write_ack_timeout(16'd0);
    send_byte(8'h12);
    send_byte(8'h00);
    send_tick();
    write_ack_timeout(16'hffff);
    send_byte(8'h34);
    send_byte(8'h01);
    send_frames(1);
    repeat (5) send_tick();
    send_byte(aur_pkg::ACK_CODE);
    // lower the limit while the acknowledge is awaited
    write_ack_timeout(16'd10);
    send_byte(8'h56);
    send_byte(8'h00);
    repeat (4) send_tick();
    write_ack_timeout(16'd2);
    send_tick();
    write_ack_timeout(16'd3);
    send_byte(8'h78);
    send_byte(8'h01);
    send_frames(1);
    repeat (4) send_tick();
    pause_until_drained();
  endtask

  task automatic test_random_stream();
    int start;
    int pick;
    int count;
    int ticks;
    for (int prof = 0; prof < 3; prof++) begin
      if (prof == 0) set_idling(14, 80);
      else if (prof == 1) set_idling(80, 14);
      else set_idling(0, 0);
      start = items_offered;
      while (items_offered - start < 10) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) write_ack_timeout(16'($urandom_range(0, 6)));
          else if (pick == 6) write_ack_timeout(16'd0);
          else if (pick == 7) write_ack_timeout(16'hffff);
          else write_ack_timeout(16'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 3)) send_tick();
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) count = $urandom_range(0, 1);
          else if (pick < 95) count = $urandom_range(2, 3);
          else count = $urandom_range(4, 6);
          send_byte(8'($urandom));
          send_byte(8'(count));
          send_frames(count);
          pick = $urandom_range(0, 99);
          if (pick < 15 && timeout_shadow <= 12) begin
            repeat (timeout_shadow + 1) send_tick();
          end else begin
            ticks = (timeout_shadow < 3) ? timeout_shadow : 3;
            repeat ($urandom_range(0, ticks)) send_tick();
            if (pick < 30) send_byte(8'($urandom_range(0, 254)));
            else send_byte(aur_pkg::ACK_CODE);
          end
        end
      end
    end
    pause_until_drained();
  endtask

  task automatic test_buffer_limits();
    set_idling(0, 0);
    // stall the receiver while a full packet and its commit pile up
    hold_len = 400;
    hold_serial++;
    send_byte(8'($urandom));
    send_byte(8'(aur_pkg::MAX_FRAMES));
    send_frames(aur_pkg::MAX_FRAMES);
    send_byte(aur_pkg::ACK_CODE);
    pause_until_drained();
    // one frame beyond the buffer
    send_byte(8'h9d);
    send_byte(8'(aur_pkg::MAX_FRAMES + 1));
    send_frames(aur_pkg::MAX_FRAMES);
    send_byte(aur_pkg::ACK_CODE);
    send_byte(8'h22);
    send_byte(8'h00);
    send_byte(aur_pkg::ACK_CODE);
    pause_until_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    set_idling(14, 80);
    test_reset_timeout();
    test_directed();
    test_timeout_register();
    test_random_stream();
    test_buffer_limits();
    pause_until_drained();
    repeat (60) @(posedge clk);
    if (bad_results == 0 && awaited_results.size() == 0) begin
      $display("PASS animation_upload_receiver_top");
    end else begin
      $display("FAIL animation_upload_receiver_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL animation_upload_receiver_top");
    $finish;
  end

endmodule
